// File: rtl/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared constants, codes and types of the debounced pulse counter.
// ----------------------------------------------------------------------------
package dpc_pkg;

	localparam int REG_W       = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int MODE_W      = 2;
	localparam int PORT_W      = 3;
	localparam int PIN_W       = 4;
	localparam int OUT_CH      = 4;
	localparam int OUT_COUNT_W = 32;
	localparam int ALARM_W     = 2;
	localparam int NUM_PORTS   = 4;
	localparam int ALARM_FIRST = 2;
	localparam int HOLDOFF_CH  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP_MIDDLE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALARM_HOLDOFF  = 2'd2;

	localparam logic [REG_W-1:0] DEBOUNCE_RESET = 8'd8;
	localparam logic [REG_W-1:0] HOLDOFF_RESET  = 8'd30;

	localparam logic [MODE_W-1:0] MODE_EDGE     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DEBOUNCE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HOLDOFF  = 2'd2;

	localparam logic [ALARM_W-1:0] ALARM_NONE = 2'd0;
	localparam logic [ALARM_W-1:0] ALARM_CH2  = 2'd1;
	localparam logic [ALARM_W-1:0] ALARM_CH3  = 2'd2;

	typedef struct packed {
		logic expired;
		logic counted;
	} chan_stat_t;

	function automatic logic [PORT_W-1:0] map_line(input logic [PORT_W-1:0] c,
		input logic swap);
		logic [PORT_W-1:0] r;
		r = c;
		if (swap && (c == 3'd1 || c == 3'd2)) begin
			r = c ^ 3'd3;
		end
		return r;
	endfunction

endpackage

// File: rtl/dpc_channel.sv
// ----------------------------------------------------------------------------
// dpc_channel
// One channel: debounce countdown, arm flag and wrapping pulse count.
// ----------------------------------------------------------------------------
module dpc_channel #(
	parameter int COUNT_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [dpc_pkg::MODE_W-1:0] mode,
	input  logic                       edge_hit,
	input  logic                       level,
	input  logic [dpc_pkg::REG_W-1:0]  debounce_ticks,
	output logic [COUNT_BITS-1:0]      count,
	output dpc_pkg::chan_stat_t        stat
);
	import dpc_pkg::*;

	logic [REG_W-1:0]      debounce_q;
	logic [REG_W-1:0]      debounce_d;
	logic                  armed_q;
	logic                  armed_d;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_d;

	always_comb begin
		debounce_d   = debounce_q;
		armed_d      = armed_q;
		count_d      = count_q;
		stat.expired = 1'b0;
		stat.counted = 1'b0;
		unique case (mode)
			MODE_EDGE: begin
				if (edge_hit && debounce_q == '0) begin
					debounce_d = debounce_ticks;
				end
			end
			MODE_DEBOUNCE: begin
				if (debounce_q != '0) begin
					debounce_d = debounce_q - 1'b1;
					if (debounce_q == REG_W'(1)) begin
						stat.expired = 1'b1;
						if (!armed_q) begin
							if (!level) begin
								armed_d      = 1'b1;
								count_d      = count_q + 1'b1;
								stat.counted = 1'b1;
							end
						end else if (level) begin
							armed_d = 1'b0;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= '0;
			armed_q    <= 1'b1;
			count_q    <= '0;
		end else if (step) begin
			debounce_q <= debounce_d;
			armed_q    <= armed_d;
			count_q    <= count_d;
		end
	end

	assign count = count_q;

endmodule

// File: rtl/dpc_alarm.sv
// ----------------------------------------------------------------------------
// dpc_alarm
// Alarm holdoff counters for channels 2 and 3 and the alarm code.
// ----------------------------------------------------------------------------
module dpc_alarm (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [dpc_pkg::MODE_W-1:0]     mode,
	input  logic [dpc_pkg::HOLDOFF_CH-1:0] expired,
	input  logic [dpc_pkg::REG_W-1:0]      alarm_holdoff,
	output logic [dpc_pkg::ALARM_W-1:0]    alarm_event
);
	import dpc_pkg::*;

	logic [REG_W-1:0]      holdoff_q [HOLDOFF_CH];
	logic [REG_W-1:0]      holdoff_d [HOLDOFF_CH];
	logic [HOLDOFF_CH-1:0] raise;

	always_comb begin
		for (int h = 0; h < HOLDOFF_CH; h++) begin
			raise[h]     = 1'b0;
			holdoff_d[h] = holdoff_q[h];
			unique case (mode)
				MODE_DEBOUNCE: begin
					if (expired[h] && holdoff_q[h] == '0) begin
						raise[h]     = 1'b1;
						holdoff_d[h] = alarm_holdoff;
					end
				end
				MODE_HOLDOFF: begin
					if (holdoff_q[h] != '0) begin
						holdoff_d[h] = holdoff_q[h] - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		priority if (raise[1]) begin
			alarm_event = ALARM_CH3;
		end else if (raise[0]) begin
			alarm_event = ALARM_CH2;
		end else begin
			alarm_event = ALARM_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int h = 0; h < HOLDOFF_CH; h++) begin
				holdoff_q[h] <= '0;
			end
		end else if (step) begin
			for (int h = 0; h < HOLDOFF_CH; h++) begin
				holdoff_q[h] <= holdoff_d[h];
			end
		end
	end

endmodule

// File: rtl/debounced_pulse_counter.sv
// ----------------------------------------------------------------------------
// debounced_pulse_counter
// Four-channel pulse counter with per-channel debounce and alarm holdoff.
// ----------------------------------------------------------------------------
// Channel   Signals                                   Handshake
// input     mode, port, pin_levels                    in_valid / in_ready
// result    count_*, counted_mask, alarm_event        out_valid / out_ready
// config    cfg_index, cfg_data                       cfg_wr_en, no wait
//
// One transaction per cycle sustained while out_ready is held high; an accepted
// input is held in the input register, then one update step moves its result
// into the result register, where out_valid raises its handshake.
// All channels update in parallel in the update step.
// The input register takes a new transaction while a stalled result waits.
// Reset sets all control, channel, alarm and config registers at once; no clearing pass.
// ----------------------------------------------------------------------------
module debounced_pulse_counter #(
	parameter int CHANNELS   = 4,
	parameter int COUNT_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [dpc_pkg::MODE_W-1:0]      mode,
	input  logic [dpc_pkg::PORT_W-1:0]      port,
	input  logic [dpc_pkg::PIN_W-1:0]       pin_levels,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [dpc_pkg::OUT_COUNT_W-1:0] count_zero,
	output logic [dpc_pkg::OUT_COUNT_W-1:0] count_one,
	output logic [dpc_pkg::OUT_COUNT_W-1:0] count_two,
	output logic [dpc_pkg::OUT_COUNT_W-1:0] count_three,
	output logic [dpc_pkg::OUT_CH-1:0]      counted_mask,
	output logic [dpc_pkg::ALARM_W-1:0]     alarm_event,
	input  logic                            cfg_wr_en,
	input  logic [dpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dpc_pkg::REG_W-1:0]       cfg_data
);
	import dpc_pkg::*;

	logic                  valid_s1;
	logic [MODE_W-1:0]     mode_s1;
	logic [PORT_W-1:0]     port_s1;
	logic [PIN_W-1:0]      pins_s1;
	logic                  advance;

	logic [REG_W-1:0]      debounce_ticks_q;
	logic                  swap_middle_q;
	logic [REG_W-1:0]      alarm_holdoff_q;

	logic                  out_valid_q;
	logic [OUT_CH-1:0]     counted_mask_q;
	logic [ALARM_W-1:0]    alarm_event_q;

	logic [COUNT_BITS-1:0] cnt [CHANNELS];
	chan_stat_t            stat [CHANNELS];
	logic [OUT_CH-1:0]     counted_vec;
	logic [HOLDOFF_CH-1:0] alarm_exp;
	logic [ALARM_W-1:0]    alarm_code;
	logic [OUT_COUNT_W-1:0] count_out [OUT_CH];
	logic                  port_valid;
	logic [PORT_W-1:0]     port_ch;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode;
			port_s1 <= port;
			pins_s1 <= pin_levels;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q <= DEBOUNCE_RESET;
			swap_middle_q    <= 1'b0;
			alarm_holdoff_q  <= HOLDOFF_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data;
				REG_SWAP_MIDDLE:    swap_middle_q    <= cfg_data[0];
				REG_ALARM_HOLDOFF:  alarm_holdoff_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign port_valid = (port_s1 < PORT_W'(NUM_PORTS)) &&
		(4'(port_s1) < 4'(CHANNELS));
	assign port_ch    = map_line(port_s1, swap_middle_q);

	for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
		logic [PORT_W-1:0] line;
		logic              level;

		assign line  = map_line(PORT_W'(c), swap_middle_q);
		assign level = (line < PORT_W'(NUM_PORTS)) ? pins_s1[line[1:0]] : 1'b0;

		dpc_channel #(
			.COUNT_BITS(COUNT_BITS)
		) u_channel (
			.clk           (clk),
			.arst_n        (arst_n),
			.step          (advance),
			.mode          (mode_s1),
			.edge_hit      (port_valid && port_ch == PORT_W'(c)),
			.level         (level),
			.debounce_ticks(debounce_ticks_q),
			.count         (cnt[c]),
			.stat          (stat[c])
		);
	end

	for (genvar i = 0; i < OUT_CH; i++) begin : g_out
		if (i < CHANNELS) begin : g_have
			assign counted_vec[i] = stat[i].counted;
			if (COUNT_BITS >= OUT_COUNT_W) begin : g_trunc
				assign count_out[i] = cnt[i][OUT_COUNT_W-1:0];
			end else begin : g_ext
				assign count_out[i] = {{(OUT_COUNT_W-COUNT_BITS){1'b0}}, cnt[i]};
			end
		end else begin : g_none
			assign counted_vec[i] = 1'b0;
			assign count_out[i]   = '0;
		end
	end

	for (genvar h = 0; h < HOLDOFF_CH; h++) begin : g_hold
		if (ALARM_FIRST + h < CHANNELS) begin : g_have
			assign alarm_exp[h] = stat[ALARM_FIRST+h].expired;
		end else begin : g_none
			assign alarm_exp[h] = 1'b0;
		end
	end

	dpc_alarm u_alarm (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.mode         (mode_s1),
		.expired      (alarm_exp),
		.alarm_holdoff(alarm_holdoff_q),
		.alarm_event  (alarm_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			counted_mask_q <= counted_vec;
			alarm_event_q  <= alarm_code;
		end
	end

	assign out_valid    = out_valid_q;
	assign counted_mask = counted_mask_q;
	assign alarm_event  = alarm_event_q;
	assign count_zero   = count_out[0];
	assign count_one    = count_out[1];
	assign count_two    = count_out[2];
	assign count_three  = count_out[3];

endmodule

// File: rtl/dpc_checker.sv
// ----------------------------------------------------------------------------
// dpc_checker
// Port-level checks of the debounced pulse counter, bound to the top level.
// ----------------------------------------------------------------------------
module dpc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [dpc_pkg::OUT_COUNT_W-1:0] count_zero,
	input logic [dpc_pkg::OUT_COUNT_W-1:0] count_three,
	input logic [dpc_pkg::OUT_CH-1:0]      counted_mask,
	input logic [dpc_pkg::ALARM_W-1:0]     alarm_event
);
	import dpc_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(counted_mask) &&
		$stable(alarm_event) && $stable(count_zero) && $stable(count_three))
		else $error("stalled transaction changed");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_count_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		count_zero != $past(count_zero) |-> out_valid)
		else $error("count changed without a result");

	a_alarm_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> alarm_event == ALARM_NONE || alarm_event == ALARM_CH2 ||
		alarm_event == ALARM_CH3)
		else $error("bad alarm code");

endmodule

bind debounced_pulse_counter dpc_checker u_dpc_checker (.*);

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// debounced_pulse_counter testbench
// Drives edge events, debounce ticks and holdoff ticks through the input
// channel and checks every result against a cycle-free model of the four
// channels: debounce countdowns, arming, pulse counts and alarm holdoffs.
// Directed cases run first, then random traffic across several register
// settings, with random gaps and stalls on both channels, a long result
// stall and drain pauses.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dpc_pkg::*;

	localparam logic [MODE_W-1:0]    MODE_SPARE  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
	localparam int                   HOLD_CYCLES = 80;
	localparam int                   SETTLE      = 4;
	localparam int                   STALL_LIMIT = 2000;

	typedef struct packed {
		logic [OUT_COUNT_W-1:0] cnt_zero;
		logic [OUT_COUNT_W-1:0] cnt_one;
		logic [OUT_COUNT_W-1:0] cnt_two;
		logic [OUT_COUNT_W-1:0] cnt_three;
		logic [OUT_CH-1:0]      mask;
		logic [ALARM_W-1:0]     alarm;
	} pulse_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [MODE_W-1:0]      mode;
	logic [PORT_W-1:0]      port;
	logic [PIN_W-1:0]       pin_levels;
	logic                   out_valid;
	logic                   out_ready;
	logic [OUT_COUNT_W-1:0] count_zero;
	logic [OUT_COUNT_W-1:0] count_one;
	logic [OUT_COUNT_W-1:0] count_two;
	logic [OUT_COUNT_W-1:0] count_three;
	logic [OUT_CH-1:0]      counted_mask;
	logic [ALARM_W-1:0]     alarm_event;
	logic                   cfg_wr_en;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [REG_W-1:0]       cfg_data;

	logic [REG_W-1:0]       cfg_debounce;
	logic                   cfg_swap;
	logic [REG_W-1:0]       cfg_holdoff;
	logic [REG_W-1:0]       countdown [OUT_CH];
	logic                   armed [OUT_CH];
	logic [OUT_COUNT_W-1:0] pulses [OUT_CH];
	logic [REG_W-1:0]       holdoff_left [HOLDOFF_CH];

	pulse_result_t pending_results[$];
	int            errors = 0;
	bit            idle_on = 1'b1;
	bit            hold_req = 1'b0;

	debounced_pulse_counter u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.port        (port),
		.pin_levels  (pin_levels),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.count_zero  (count_zero),
		.count_one   (count_one),
		.count_two   (count_two),
		.count_three (count_three),
		.counted_mask(counted_mask),
		.alarm_event (alarm_event),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [PIN_W-1:0] rand_pins();
		logic [PIN_W-1:0] v;
		v = PIN_W'($urandom_range(0, 15));
		return v;
	endfunction

	function automatic int chan_line(input int c);
		if (cfg_swap && (c == 1 || c == 2)) begin
			return c ^ 3;
		end
		return c;
	endfunction

	function automatic void reset_model();
		cfg_debounce = DEBOUNCE_RESET;
		cfg_swap     = 1'b0;
		cfg_holdoff  = HOLDOFF_RESET;
		for (int c = 0; c < OUT_CH; c++) begin
			countdown[c] = '0;
			armed[c]     = 1'b1;
			pulses[c]    = '0;
		end
		for (int h = 0; h < HOLDOFF_CH; h++) begin
			holdoff_left[h] = '0;
		end
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [REG_W-1:0] data);
		case (idx)
			REG_DEBOUNCE_TICKS: cfg_debounce = data;
			REG_SWAP_MIDDLE:    cfg_swap = data[0];
			REG_ALARM_HOLDOFF:  cfg_holdoff = data;
			default: ;
		endcase
	endfunction

	function automatic pulse_result_t predict_result(input logic [MODE_W-1:0] m,
		input logic [PORT_W-1:0] p, input logic [PIN_W-1:0] pins);
		pulse_result_t r;
		int            ch;
		logic          lvl;
		r.mask  = '0;
		r.alarm = ALARM_NONE;
		case (m)
			MODE_EDGE: begin
				if (p < NUM_PORTS) begin
					ch = chan_line(int'(p));
					if (countdown[ch] == 0) begin
						countdown[ch] = cfg_debounce;
					end
				end
			end
			MODE_DEBOUNCE: begin
				for (int c = 0; c < OUT_CH; c++) begin
					if (countdown[c] != 0) begin
						countdown[c] = countdown[c] - 1'b1;
						if (countdown[c] == 0) begin
							lvl = pins[chan_line(c)];
							if (!armed[c]) begin
								if (!lvl) begin
									armed[c]  = 1'b1;
									pulses[c] = pulses[c] + 1'b1;
									r.mask[c] = 1'b1;
								end
							end else if (lvl) begin
								armed[c] = 1'b0;
							end
							if (c >= ALARM_FIRST && holdoff_left[c - ALARM_FIRST] == 0) begin
								r.alarm = (c == ALARM_FIRST) ? ALARM_CH2 : ALARM_CH3;
								holdoff_left[c - ALARM_FIRST] = cfg_holdoff;
							end
						end
					end
				end
			end
			MODE_HOLDOFF: begin
				for (int h = 0; h < HOLDOFF_CH; h++) begin
					if (holdoff_left[h] != 0) begin
						holdoff_left[h] = holdoff_left[h] - 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.cnt_zero  = pulses[0];
		r.cnt_one   = pulses[1];
		r.cnt_two   = pulses[2];
		r.cnt_three = pulses[3];
		return r;
	endfunction

	task automatic send_item(input logic [MODE_W-1:0] m, input logic [PORT_W-1:0] p,
		input logic [PIN_W-1:0] pins);
		in_valid   <= 1'b1;
		mode       <= m;
		port       <= p;
		pin_levels <= pins;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_result(m, p, pins));
		if (idle_on && $urandom_range(0, 99) < 25) begin
			in_valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input logic [REG_W-1:0] deb, input logic swap,
		input logic [REG_W-1:0] hold);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [REG_W-1:0]     val [4];
		logic [REG_W-2:0]     filler;
		wait_idle();
		filler = (REG_W-1)'($urandom_range(0, 127));
		idx    = '{REG_DEBOUNCE_TICKS, REG_SWAP_MIDDLE, REG_ALARM_HOLDOFF, REG_SPARE};
		val[0] = deb;
		val[1] = {filler, swap};
		val[2] = hold;
		val[3] = REG_W'($urandom_range(0, 255));
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			apply_register(idx[i], val[i]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_random_item();
		int                r;
		logic [MODE_W-1:0] m;
		logic [PORT_W-1:0] p;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			m = MODE_EDGE;
		end else if (r < 80) begin
			m = MODE_DEBOUNCE;
		end else if (r < 95) begin
			m = MODE_HOLDOFF;
		end else begin
			m = MODE_SPARE;
		end
		if ($urandom_range(0, 99) < 85) begin
			p = PORT_W'($urandom_range(0, 3));
		end else begin
			p = PORT_W'($urandom_range(4, 7));
		end
		send_item(m, p, rand_pins());
	endtask

	// edge followed by exactly enough ticks to reach the pin sample, mixed with random items
	task automatic send_random_traffic(input int n_items);
		int               sent;
		logic [PORT_W-1:0] p;
		sent = 0;
		while (sent < n_items) begin
			if (cfg_debounce != 0 && cfg_debounce <= 8 && $urandom_range(0, 99) < 55) begin
				p = PORT_W'($urandom_range(0, 3));
				send_item(MODE_EDGE, p, rand_pins());
				repeat (cfg_debounce) send_item(MODE_DEBOUNCE, '0, rand_pins());
				if ($urandom_range(0, 99) < 30) begin
					send_item(MODE_HOLDOFF, '0, rand_pins());
					sent++;
				end
				sent += 1 + cfg_debounce;
			end else begin
				send_random_item();
				sent++;
			end
		end
	endtask

	task automatic test_channel_basics();
		set_config(8'd1, 1'b0, 8'd2);
		for (int p = 0; p < NUM_PORTS; p++) begin
			send_item(MODE_EDGE, PORT_W'(p), rand_pins());
		end
		send_item(MODE_DEBOUNCE, '0, 4'hF);
		for (int p = 0; p < NUM_PORTS; p++) begin
			send_item(MODE_EDGE, PORT_W'(p), rand_pins());
		end
		send_item(MODE_DEBOUNCE, '0, 4'h0);
		repeat (3) send_item(MODE_HOLDOFF, '0, rand_pins());
		send_item(MODE_EDGE, 3'd4, 4'hF);
		send_item(MODE_EDGE, 3'd7, 4'hF);
		send_item(MODE_SPARE, 3'd7, 4'hF);
		send_item(MODE_EDGE, 3'd3, 4'h0);
		send_item(MODE_DEBOUNCE, '0, 4'h0);
	endtask

	task automatic test_swap_and_zero_debounce();
		set_config(8'd1, 1'b1, 8'd1);
		send_item(MODE_EDGE, 3'd1, rand_pins());
		send_item(MODE_DEBOUNCE, '0, 4'b0010);
		send_item(MODE_EDGE, 3'd2, rand_pins());
		send_item(MODE_DEBOUNCE, '0, 4'b0100);
		set_config(8'd0, 1'b0, 8'd1);
		send_item(MODE_EDGE, 3'd0, rand_pins());
		send_item(MODE_DEBOUNCE, '0, 4'h0);
	endtask

	task automatic test_random_settings();
		int   deb_set [8];
		bit   swap_set [8];
		int   hold_set [8];
		deb_set  = '{8, 1, 2, 255, 3, 1, 4, 0};
		swap_set = '{0, 0, 1, 1, 0, 1, 1, 0};
		hold_set = '{30, 1, 3, 255, 2, 255, 1, 0};
		deb_set[7]  = $urandom_range(1, 255);
		swap_set[7] = 1'($urandom_range(0, 1));
		hold_set[7] = $urandom_range(1, 255);
		for (int i = 0; i < 8; i++) begin
			set_config(REG_W'(deb_set[i]), swap_set[i], REG_W'(hold_set[i]));
			idle_on = (i != 2);
			send_random_traffic(180);
		end
		idle_on = 1'b1;
	endtask

	task automatic test_output_backpressure();
		set_config(8'd2, 1'b0, 8'd5);
		hold_req = 1'b1;
		send_random_traffic(200);
	endtask

	task automatic test_sender_pause();
		set_config(8'd1, 1'b1, 8'd1);
		for (int i = 0; i < 12; i++) begin
			send_random_traffic(20);
			wait_idle();
		end
	endtask

	initial begin : result_receiver
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 99) < 10) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input logic [OUT_COUNT_W-1:0] e,
		input logic [OUT_COUNT_W-1:0] a);
		if (e !== a) begin
			$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_check
		pulse_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, count_zero 0x%0h", $time, count_zero);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("count_zero", want.cnt_zero, count_zero);
				check_field("count_one", want.cnt_one, count_one);
				check_field("count_two", want.cnt_two, count_two);
				check_field("count_three", want.cnt_three, count_three);
				check_field("counted_mask", OUT_COUNT_W'(want.mask),
					OUT_COUNT_W'(counted_mask));
				check_field("alarm_event", OUT_COUNT_W'(want.alarm),
					OUT_COUNT_W'(alarm_event));
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("debounced_pulse_counter test failed");
		$finish;
	end

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		mode       <= MODE_EDGE;
		port       <= '0;
		pin_levels <= '0;
		cfg_wr_en  <= 1'b0;
		cfg_index  <= REG_DEBOUNCE_TICKS;
		cfg_data   <= '0;
		reset_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_channel_basics();
		test_swap_and_zero_debounce();
		test_random_settings();
		test_output_backpressure();
		test_sender_pause();
		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("debounced_pulse_counter test passed");
		end else begin
			$display("debounced_pulse_counter test failed");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/dpc_pkg.sv
rtl/dpc_channel.sv
rtl/dpc_alarm.sv
rtl/debounced_pulse_counter.sv
rtl/dpc_checker.sv
dv/testbench.sv
